// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBRP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBRP_ASSERT(lbl, prop, msg)
`define SBRP_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- src/sbrp_pkg.sv -----
// constants, status codes and types of the binding reply parser
`default_nettype none
package sbrp_pkg;

  localparam int unsigned MaxBytesDef = 2048;
  localparam int unsigned OffW        = 18;
  localparam int unsigned HdrBytes    = 20;
  localparam int unsigned MinBody     = 12;

  localparam logic [15:0] TypeBindingOk = 16'h0101;
  localparam logic [15:0] AttrXorMapped = 16'h0020;
  localparam logic [15:0] MappedLen     = 16'd8;
  localparam logic [15:0] CookieHi      = 16'h2112;
  localparam logic [31:0] Cookie        = 32'h2112_A442;
  localparam logic [7:0]  FamilyV4      = 8'h01;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StShort     = 3'd1;
  localparam logic [2:0] StWrongType = 3'd2;
  localparam logic [2:0] StLenSmall  = 3'd3;
  localparam logic [2:0] StTrunc     = 3'd4;
  localparam logic [2:0] StOverrun   = 3'd5;
  localparam logic [2:0] StBadMapped = 3'd6;
  localparam logic [2:0] StNotFound  = 3'd7;

  // view of the parse state after the current item, for the verdict
  typedef struct packed {
    logic        short_pkt;
    logic        fits;
    logic [15:0] htype;
    logic [15:0] blen;
    logic [2:0]  verdict;
    logic [15:0] port;
    logic [31:0] addr;
  } walk_sum_t;

endpackage
`default_nettype wire

// ----- src/sbrp_walk.sv -----
// header capture and attribute walk, one byte per cycle while take_i is high
`default_nettype none
module sbrp_walk import sbrp_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      take_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      last_byte_i,
  output walk_sum_t      sum_o
);

  localparam int unsigned CntW = $clog2(MaxBytes + 1);

  logic [CntW-1:0] cnt_q, cnt_d, n_next;
  logic [15:0]     htype_q, htype_d;
  logic [15:0]     blen_q, blen_d, blen_new;
  logic [OffW-1:0] off_q, off_d;
  logic [15:0]     kind_q, kind_d;
  logic [15:0]     size_q, size_d, size_new;
  logic [2:0]      verdict_q, verdict_d;
  logic            done_q, done_d;
  logic [15:0]     port_q, port_d;
  logic [31:0]     addr_q, addr_d;

  logic            in_range;
  logic [OffW-1:0] pos, rel, msg_end, padded, stop;

  // 0 nothing, 1 end of message reached, 2 no room for an attribute header
  function automatic logic [1:0] classify(input logic [OffW-1:0] off,
                                          input logic [OffW-1:0] lim);
    logic [1:0] r;
    r = 2'd0;
    if (off >= lim) r = 2'd1;
    else if (off + OffW'(4) > lim) r = 2'd2;
    return r;
  endfunction

  assign in_range = cnt_q < CntW'(MaxBytes);
  assign pos      = OffW'(cnt_q);
  assign rel      = pos - off_q;
  assign blen_new = (cnt_q == CntW'(3)) ? {blen_q[15:8], data_byte_i} : blen_q;
  assign msg_end  = OffW'(blen_new) + OffW'(HdrBytes);
  assign size_new = {size_q[15:8], data_byte_i};
  assign padded   = (OffW'(size_new) + OffW'(3)) & ~OffW'(3);
  assign stop     = off_q + OffW'(4) + padded;

  always_comb begin
    logic [1:0] cls;
    cls       = 2'd0;
    cnt_d     = cnt_q;
    htype_d   = htype_q;
    blen_d    = blen_q;
    off_d     = off_q;
    kind_d    = kind_q;
    size_d    = size_q;
    verdict_d = verdict_q;
    done_d    = done_q;
    port_d    = port_q;
    addr_d    = addr_q;
    if (take_i && in_range) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(0)) begin
        htype_d = {data_byte_i, 8'h00};
      end else if (cnt_q == CntW'(1)) begin
        htype_d = {htype_q[15:8], data_byte_i};
      end else if (cnt_q == CntW'(2)) begin
        blen_d = {data_byte_i, 8'h00};
      end else if (cnt_q == CntW'(3)) begin
        blen_d = blen_new;
        off_d  = OffW'(HdrBytes);
        cls    = classify(OffW'(HdrBytes), msg_end);
      end else if (pos >= OffW'(HdrBytes) && !done_q && pos >= off_q &&
                   rel < OffW'(12)) begin
        case (rel[3:0])
          4'd0: kind_d = {data_byte_i, 8'h00};
          4'd1: kind_d = {kind_q[15:8], data_byte_i};
          4'd2: size_d = {data_byte_i, 8'h00};
          4'd3: begin
            size_d = size_new;
            if (stop > msg_end) begin
              done_d    = 1'b1;
              verdict_d = StOverrun;
            end else if (kind_q == AttrXorMapped) begin
              if (size_new != MappedLen) begin
                done_d    = 1'b1;
                verdict_d = StBadMapped;
              end
            end else begin
              off_d = stop;
              cls   = classify(stop, msg_end);
            end
          end
          4'd5: begin
            if (data_byte_i != FamilyV4) begin
              done_d    = 1'b1;
              verdict_d = StBadMapped;
            end
          end
          4'd6:  port_d = {data_byte_i, 8'h00};
          4'd7:  port_d = {port_q[15:8], data_byte_i} ^ CookieHi;
          4'd8:  addr_d = {data_byte_i, 24'h000000};
          4'd9:  addr_d = {addr_q[31:24], data_byte_i, 16'h0000};
          4'd10: addr_d = {addr_q[31:16], data_byte_i, 8'h00};
          4'd11: begin
            addr_d    = {addr_q[31:8], data_byte_i} ^ Cookie;
            done_d    = 1'b1;
            verdict_d = StOk;
          end
          default: ;
        endcase
      end
      if (cls == 2'd1) begin
        done_d    = 1'b1;
        verdict_d = StNotFound;
      end else if (cls == 2'd2) begin
        done_d    = 1'b1;
        verdict_d = StOverrun;
      end
    end
  end

  assign n_next = in_range ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    sum_o.short_pkt = n_next < CntW'(HdrBytes);
    sum_o.fits      = OffW'(blen_d) + OffW'(HdrBytes) <= OffW'(n_next);
    sum_o.htype     = htype_d;
    sum_o.blen      = blen_d;
    sum_o.verdict   = verdict_d;
    sum_o.port      = port_d;
    sum_o.addr      = addr_d;
  end

  // the last byte of a datagram returns the walk to its reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      htype_q   <= '0;
      blen_q    <= '0;
      off_q     <= OffW'(HdrBytes);
      kind_q    <= '0;
      size_q    <= '0;
      verdict_q <= StNotFound;
      done_q    <= 1'b0;
      port_q    <= '0;
      addr_q    <= '0;
    end else if (take_i && last_byte_i) begin
      cnt_q     <= '0;
      htype_q   <= '0;
      blen_q    <= '0;
      off_q     <= OffW'(HdrBytes);
      kind_q    <= '0;
      size_q    <= '0;
      verdict_q <= StNotFound;
      done_q    <= 1'b0;
      port_q    <= '0;
      addr_q    <= '0;
    end else begin
      cnt_q     <= cnt_d;
      htype_q   <= htype_d;
      blen_q    <= blen_d;
      off_q     <= off_d;
      kind_q    <= kind_d;
      size_q    <= size_d;
      verdict_q <= verdict_d;
      done_q    <= done_d;
      port_q    <= port_d;
      addr_q    <= addr_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/sbrp_result.sv -----
// verdict priority and output register
`default_nettype none
module sbrp_result import sbrp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_last_i,
  input  walk_sum_t        sum_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic [31:0]      mapped_address_o,
  output logic [15:0]      mapped_port_o
);

  logic        valid_q, valid_d;
  logic [2:0]  status_q, status_d;
  logic [31:0] addr_q;
  logic [15:0] port_q;

  always_comb begin
    if (sum_i.short_pkt) status_d = StShort;
    else if (sum_i.htype != TypeBindingOk) status_d = StWrongType;
    else if (sum_i.blen < 16'(MinBody)) status_d = StLenSmall;
    else if (!sum_i.fits) status_d = StTrunc;
    else status_d = sum_i.verdict;
  end

  always_comb begin
    valid_d = valid_q;
    if (take_last_i) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_last_i) begin
      status_q <= status_d;
      addr_q   <= (status_d == StOk) ? sum_i.addr : 32'h0;
      port_q   <= (status_d == StOk) ? sum_i.port : 16'h0;
    end
  end

  assign out_valid_o      = valid_q;
  assign status_o         = status_q;
  assign mapped_address_o = addr_q;
  assign mapped_port_o    = port_q;

endmodule
`default_nettype wire

// ----- src/stun_binding_reply_parser.sv -----
// top level of the binding reply parser
//
//   channel | signals                                     | moves
//   in      | in_valid_i/in_ready_o, data_byte_i, last_byte_i | one datagram byte
//   out     | out_valid_o/out_ready_i, status_o,              | one verdict per datagram
//           | mapped_address_o, mapped_port_o                 |
//
// one byte per cycle unless a last byte stalls; the verdict is registered and appears in the cycle after the last byte
// per-byte state update is a few compares and 18-bit adds on the walk registers
// the output register holds one verdict; non-last bytes flow while it waits
// a last byte stalls only while an untaken verdict sits in the output register
// reset (async, active low) clears the walk state and empties the output
`default_nettype none
`include "assert_macros.svh"
module stun_binding_reply_parser import sbrp_pkg::*; #(
  parameter int unsigned MaxBytes = MaxBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [31:0]      mapped_address_o,
  output logic [15:0]      mapped_port_o
);

  logic      take;
  walk_sum_t sum;

  assign in_ready_o = !out_valid_o || out_ready_i || !last_byte_i;
  assign take       = in_valid_i && in_ready_o;

  sbrp_walk #(
    .MaxBytes(MaxBytes)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .sum_o       (sum)
  );

  sbrp_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_last_i      (take && last_byte_i),
    .sum_i            (sum),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .mapped_address_o (mapped_address_o),
    .mapped_port_o    (mapped_port_o)
  );

  `SBRP_ASSERT(a_fail_zero,
    out_valid_o && status_o != StOk |->
      mapped_address_o == 32'h0 && mapped_port_o == 16'h0,
    "failed verdict carries address")
  `SBRP_ASSERT(a_stall_cause,
    !in_ready_o |-> out_valid_o && last_byte_i,
    "input stalled without a waiting verdict")
  `SBRP_ASSERT(a_last_gives,
    in_valid_i && in_ready_o && last_byte_i |=> out_valid_o,
    "last byte gave no verdict")
  `SBRP_ASSERT_NR(a_reset_empty, !rst_ni |=> !out_valid_o, "verdict valid after reset")

endmodule
`default_nettype wire

// ----- sim/tb_stun_binding_reply_parser.sv -----
// stun binding reply parser testbench: directed and random datagrams checked per verdict
`timescale 1ns / 1ps
module tb_stun_binding_reply_parser;
  import sbrp_pkg::*;

  localparam int CycleLimit = 400000;

  // receiver stall patterns
  localparam int RxAlways  = 0;
  localparam int RxRandom  = 1;
  localparam int RxPattern = 2;
  localparam int RxSparse  = 3;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] port;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] mapped_address_o;
  logic [15:0] mapped_port_o;

  stun_binding_reply_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .mapped_address_o (mapped_address_o),
    .mapped_port_o    (mapped_port_o)
  );

  always #1 clk_i = ~clk_i;

  // predicted parse state
  logic [11:0] pos_cnt;
  logic [15:0] msg_type;
  logic [15:0] msg_len;
  logic [17:0] attr_off;
  logic [15:0] attr_type;
  logic [15:0] attr_len;
  logic [2:0]  walk_st;
  bit          walk_fin;
  logic [15:0] xport;
  logic [31:0] xaddr;

  verdict_t    verdict_q[$];
  logic [7:0]  frame[$];
  int          errors = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          rx_mode = RxAlways;
  int          stall_ph = 0;
  bit          gaps_on = 1'b0;

  task automatic clear_parse();
    pos_cnt   = '0;
    msg_type  = '0;
    msg_len   = '0;
    attr_off  = 18'(HdrBytes);
    attr_type = '0;
    attr_len  = '0;
    walk_st   = StNotFound;
    walk_fin  = 1'b0;
    xport     = '0;
    xaddr     = '0;
  endtask

  function automatic logic [17:0] msg_end();
    return {2'b00, msg_len} + 18'(HdrBytes);
  endfunction

  task automatic finish_walk(input logic [2:0] st);
    walk_st  = st;
    walk_fin = 1'b1;
  endtask

  task automatic check_attr_start();
    if (attr_off >= msg_end()) begin
      finish_walk(StNotFound);
    end else if (attr_off + 18'd4 > msg_end()) begin
      finish_walk(StOverrun);
    end
  endtask

  task automatic take_byte(input logic [11:0] p, input logic [7:0] b);
    logic [17:0] rel;
    logic [17:0] padded;
    logic [17:0] stop;
    case (p)
      12'd0: msg_type = {b, 8'h00};
      12'd1: msg_type[7:0] = b;
      12'd2: msg_len = {b, 8'h00};
      12'd3: begin
        msg_len[7:0] = b;
        attr_off = 18'(HdrBytes);
        check_attr_start();
      end
      default: begin
        if (p < HdrBytes || walk_fin || {6'b0, p} < attr_off) return;
        rel = {6'b0, p} - attr_off;
        case (rel)
          18'd0: attr_type = {b, 8'h00};
          18'd1: attr_type[7:0] = b;
          18'd2: attr_len = {b, 8'h00};
          18'd3: begin
            attr_len[7:0] = b;
            padded = ({2'b00, attr_len} + 18'd3) & ~18'd3;
            stop = attr_off + 18'd4 + padded;
            if (stop > msg_end()) begin
              finish_walk(StOverrun);
            end else if (attr_type == AttrXorMapped) begin
              if (attr_len != MappedLen) finish_walk(StBadMapped);
            end else begin
              attr_off = stop;
              check_attr_start();
            end
          end
          18'd5: if (b != FamilyV4) finish_walk(StBadMapped);
          18'd6: xport = {b, 8'h00};
          18'd7: xport = {xport[15:8], b} ^ CookieHi;
          18'd8: xaddr = {b, 24'h000000};
          18'd9: xaddr[23:16] = b;
          18'd10: xaddr[15:8] = b;
          18'd11: begin
            xaddr = {xaddr[31:8], b} ^ Cookie;
            finish_walk(StOk);
          end
          default: ;
        endcase
      end
    endcase
  endtask

  // one accepted byte; a last byte queues the expected verdict
  task automatic parse_byte(input logic [7:0] b, input logic lb);
    verdict_t    v;
    logic [2:0]  st;
    // bytes past the receive buffer are dropped
    if (pos_cnt < MaxBytesDef) begin
      take_byte(pos_cnt, b);
      pos_cnt = pos_cnt + 12'd1;
    end
    if (lb) begin
      if (pos_cnt < HdrBytes) st = StShort;
      else if (msg_type != TypeBindingOk) st = StWrongType;
      else if (msg_len < MinBody) st = StLenSmall;
      else if (msg_end() > {6'b0, pos_cnt}) st = StTrunc;
      else st = walk_st;
      v.status = st;
      v.addr   = (st == StOk) ? xaddr : 32'h0;
      v.port   = (st == StOk) ? xport : 16'h0;
      verdict_q.push_back(v);
      clear_parse();
    end
  endtask

  initial clear_parse();

  // monitor: predict on accepted bytes, then check accepted verdicts
  always @(posedge clk_i) begin : monitor
    verdict_t exp_v;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parse_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t unexpected verdict: status %0d address %h port %h", $time,
                   status_o, mapped_address_o, mapped_port_o);
        end else begin
          exp_v = verdict_q.pop_front();
          if (status_o !== exp_v.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time,
                     exp_v.status, status_o);
          end
          if (mapped_address_o !== exp_v.addr) begin
            errors++;
            $display("%0t address mismatch: expected %h, actual %h", $time,
                     exp_v.addr, mapped_address_o);
          end
          if (mapped_port_o !== exp_v.port) begin
            errors++;
            $display("%0t port mismatch: expected %h, actual %h", $time,
                     exp_v.port, mapped_port_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    stall_ph <= stall_ph + 1;
    case (rx_mode)
      RxRandom:  out_ready_i <= ($urandom_range(0, 3) != 0);
      RxPattern: out_ready_i <= ((stall_ph % 13) < 5);
      RxSparse:  out_ready_i <= ($urandom_range(0, 7) == 0);
      default:   out_ready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lb);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lb;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic push16(input logic [15:0] v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endtask

  task automatic push_random(input int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // header with a zero length; cookie and transaction id are random
  task automatic frame_header(input logic [15:0] mtype);
    frame.delete();
    push16(mtype);
    push16(16'h0000);
    push_random(16);
  endtask

  task automatic set_len(input logic [15:0] v);
    frame[2] = v[15:8];
    frame[3] = v[7:0];
  endtask

  task automatic fit_len();
    set_len(16'(frame.size() - HdrBytes));
  endtask

  task automatic add_tlv(input logic [15:0] atype, input int alen);
    push16(atype);
    push16(16'(alen));
    push_random((alen + 3) & ~3);
  endtask

  task automatic add_mapped(input logic [15:0] port, input logic [31:0] addr,
                            input logic [7:0] family);
    push16(AttrXorMapped);
    push16(MappedLen);
    push_random(1);
    frame.push_back(family);
    push16(port ^ CookieHi);
    push16(addr[31:16] ^ Cookie[31:16]);
    push16(addr[15:0] ^ Cookie[15:0]);
  endtask

  task automatic test_short_frames();
    gaps_on = 1'b0;
    rx_mode = RxAlways;
    frame.delete();
    push_random(1);
    send_frame();
    frame_header(TypeBindingOk);
    void'(frame.pop_back());
    send_frame();
  endtask

  task automatic test_header_errors();
    gaps_on = 1'b1;
    rx_mode = RxRandom;
    frame_header(16'h0100);
    add_mapped(16'h1234, 32'h0a000001, FamilyV4);
    fit_len();
    send_frame();
    frame_header(16'hffff);
    send_frame();
    // message length below the minimum
    frame_header(TypeBindingOk);
    send_frame();
    frame_header(TypeBindingOk);
    push_random(11);
    set_len(16'd11);
    send_frame();
    // message longer than the datagram
    frame_header(TypeBindingOk);
    add_mapped(16'h4321, 32'hc0a80001, FamilyV4);
    set_len(16'd16);
    send_frame();
    frame_header(TypeBindingOk);
    add_mapped(16'h4321, 32'hc0a80001, FamilyV4);
    set_len(16'hffff);
    send_frame();
  endtask

  task automatic test_mapped_decode();
    gaps_on = 1'b1;
    rx_mode = RxPattern;
    frame_header(TypeBindingOk);
    add_mapped(16'h0000, 32'h00000000, FamilyV4);
    fit_len();
    send_frame();
    frame_header(TypeBindingOk);
    add_mapped(16'hffff, 32'hffffffff, FamilyV4);
    fit_len();
    send_frame();
    // odd-length attribute ahead, padding skipped; trailing bytes past the message
    frame_header(TypeBindingOk);
    add_tlv(16'h8022, 5);
    add_mapped(16'h1f90, 32'h5db8d822, FamilyV4);
    add_tlv(16'h8028, 4);
    fit_len();
    push_random(3);
    send_frame();
    // only the first mapped attribute counts
    frame_header(TypeBindingOk);
    add_mapped(16'haaaa, 32'h55aa55aa, FamilyV4);
    add_mapped(16'h5555, 32'haa55aa55, FamilyV4);
    fit_len();
    send_frame();
  endtask

  task automatic test_walk_errors();
    gaps_on = 1'b0;
    rx_mode = RxSparse;
    // attribute value runs past the message end
    frame_header(TypeBindingOk);
    add_tlv(16'h8022, 20);
    set_len(16'd12);
    send_frame();
    // fewer than four bytes left for the next attribute header
    frame_header(TypeBindingOk);
    add_tlv(16'h8022, 8);
    push_random(2);
    fit_len();
    send_frame();
    // mapped attribute with the wrong length or family
    frame_header(TypeBindingOk);
    add_tlv(AttrXorMapped, 4);
    add_tlv(16'h0001, 4);
    fit_len();
    send_frame();
    frame_header(TypeBindingOk);
    add_mapped(16'h0101, 32'h01010101, 8'h02);
    add_mapped(16'h0202, 32'h02020202, FamilyV4);
    fit_len();
    send_frame();
    // walk reaches the message end exactly
    frame_header(TypeBindingOk);
    add_tlv(16'h8022, 8);
    fit_len();
    send_frame();
    frame_header(TypeBindingOk);
    add_tlv(16'h0021, 8);
    add_tlv(16'h0000, 0);
    fit_len();
    send_frame();
  endtask

  task automatic test_oversize();
    gaps_on = 1'b1;
    rx_mode = RxRandom;
    // message ends exactly at the buffer limit, trailing bytes past it are dropped
    frame_header(TypeBindingOk);
    add_tlv(16'h8022, MaxBytesDef - HdrBytes - 16);
    add_mapped(16'h7fff, 32'h80000000, FamilyV4);
    fit_len();
    push_random(3);
    send_frame();
  endtask

  task automatic build_random_frame();
    int kind;
    int blen;
    int cut;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      frame_header(TypeBindingOk);
      repeat ($urandom_range(0, 2)) add_tlv(16'($urandom_range(0, 65535)), $urandom_range(0, 13));
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) != 0) begin
          add_mapped(16'($urandom), $urandom,
                     ($urandom_range(0, 7) != 0) ? FamilyV4 : 8'($urandom_range(0, 255)));
        end else begin
          add_tlv(AttrXorMapped, $urandom_range(0, 12));
        end
      end
      if ($urandom_range(0, 1) != 0) begin
        repeat ($urandom_range(0, 2)) add_tlv(16'($urandom_range(0, 65535)), $urandom_range(0, 8));
      end
      blen = frame.size() - HdrBytes;
      if ($urandom_range(0, 4) == 0) blen = blen + $urandom_range(0, 12) - 6;
      if (blen < 0) blen = 0;
      set_len(16'(blen));
      if ($urandom_range(0, 4) == 0) push_random($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end else begin
      // noise, sometimes with a plausible header
      n = $urandom_range(1, 40);
      frame.delete();
      push_random(n);
      if (n >= 2 && $urandom_range(0, 1) != 0) begin
        frame[0] = TypeBindingOk[15:8];
        frame[1] = TypeBindingOk[7:0];
      end
      if (n >= 4 && $urandom_range(0, 1) != 0) begin
        frame[2] = 8'h00;
        frame[3] = 8'($urandom_range(0, 30));
      end
    end
  endtask

  task automatic test_random_traffic(input int byte_goal, input int frame_goal,
                                     input bit use_gaps, input int stall_mode);
    int first_byte;
    int frames;
    first_byte = bytes_sent;
    frames = 0;
    gaps_on = use_gaps;
    rx_mode = stall_mode;
    while (bytes_sent - first_byte < byte_goal || frames < frame_goal) begin
      build_random_frame();
      send_frame();
      frames++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_frames();
    test_header_errors();
    test_mapped_decode();
    test_walk_errors();
    test_oversize();
    test_random_traffic(120, 6, 1'b1, RxRandom);
    test_random_traffic(100, 6, 1'b0, RxAlways);
    test_random_traffic(100, 6, 1'b1, RxPattern);
    test_random_traffic(100, 6, 1'b1, RxSparse);
    in_valid_i <= 1'b0;
    rx_mode = RxAlways;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- stun_binding_reply_parser.f -----
+incdir+src
src/sbrp_pkg.sv
src/sbrp_walk.sv
src/sbrp_result.sv
src/stun_binding_reply_parser.sv
sim/tb_stun_binding_reply_parser.sv
